### rtl/rcpwc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes of the RC pulse width capture block.
package rcpwc_pkg;

    localparam int CHANNELS_DEF     = 6;
    localparam int TICKS_PER_US_DEF = 120;
    localparam int STAMP_BITS_DEF   = 24;

    localparam int CHANNEL_BITS  = 3;
    localparam int IN_STAMP_BITS = 24;
    localparam int KIND_BITS     = 2;
    localparam int WIDTH_US_BITS = 18;
    localparam int HELD_BITS     = 12;

    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = HELD_BITS;

    localparam logic [HELD_BITS-1:0]     MIN_WIDTH_RST = 12'd800;
    localparam logic [HELD_BITS-1:0]     MAX_WIDTH_RST = 12'd2200;
    localparam logic [WIDTH_US_BITS-1:0] WIDTH_US_MAX  = {WIDTH_US_BITS{1'b1}};

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MIN_WIDTH = 4'd0,
        REG_MAX_WIDTH = 4'd1
    } cfg_reg_t;

    typedef enum logic [KIND_BITS-1:0] {
        EV_RISE    = 2'd0,
        EV_ACCEPT  = 2'd1,
        EV_REJECT  = 2'd2,
        EV_IGNORED = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0]  channel;
        logic [IN_STAMP_BITS-1:0] stamp;
    } rcpwc_req_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0]  out_channel;
        event_kind_t              event_kind;
        logic [WIDTH_US_BITS-1:0] width_us;
        logic [HELD_BITS-1:0]     held_width_us;
    } rcpwc_res_t;

endpackage

### rtl/rcpwc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module rcpwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/rc_pulse_width_capture.sv
`timescale 1ns / 1ps
// Multi-channel RC pulse width capture: edge events in, one result per event out.
//
// Takes one edge event per clock while the output side is not stalled and presents one
// result per event, in order, from the b, c, d and output registers. Rise stamps live in
// a per-channel RAM that is read and written on the accepting cycle; accepted widths
// live in a second per-channel RAM that is read as an event enters the last stage and
// written as it leaves it, with a forwarding register for a write that lands on the
// cycle of the read. The width is (rise - fall) mod 2^STAMP_BITS divided by TICKS_PER_US
// through an exact reciprocal multiply. Flags and accepted-width valid bits reset at
// once, so the block takes requests right after reset. Events for channels at or above
// CHANNELS are answered with kind "ignored" and change no state.
module rc_pulse_width_capture #(
    parameter int CHANNELS     = rcpwc_pkg::CHANNELS_DEF,
    parameter int TICKS_PER_US = rcpwc_pkg::TICKS_PER_US_DEF,
    parameter int STAMP_BITS   = rcpwc_pkg::STAMP_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  rcpwc_pkg::rcpwc_req_t                s_req,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output rcpwc_pkg::rcpwc_res_t                m_res,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rcpwc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rcpwc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import rcpwc_pkg::*;

    localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DIV_L      = $clog2(TICKS_PER_US);
    localparam int DIV_SHIFT  = STAMP_BITS + DIV_L;
    localparam int RECIP_BITS = STAMP_BITS + 1;
    localparam int PROD_BITS  = STAMP_BITS + RECIP_BITS;
    localparam logic [63:0] DIV_NUM    = 64'd1 << DIV_SHIFT;
    localparam logic [63:0] RECIP_FULL =
        (DIV_NUM + 64'(TICKS_PER_US) - 64'd1) / 64'(TICKS_PER_US);
    localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_FULL);

    // configuration
    logic [HELD_BITS-1:0] min_width_reg, min_width_next;
    logic [HELD_BITS-1:0] max_width_reg, max_width_next;

    // per-channel flags
    logic [CHANNELS-1:0] expect_rise_reg, expect_rise_next;
    logic [CHANNELS-1:0] acc_vld_reg, acc_vld_next;

    // pipeline control
    logic b_valid_reg, b_valid_next;
    logic c_valid_reg, c_valid_next;
    logic d_valid_reg, d_valid_next;
    logic out_valid_reg, out_valid_next;
    logic accept, b_go, c_go, d_go;
    logic b_free, c_free, d_free, out_free;

    // stage payload
    logic [CHANNEL_BITS-1:0] b_ch_reg, c_ch_reg, d_ch_reg;
    logic                    b_in_range_reg, c_in_range_reg, d_in_range_reg;
    logic                    b_rise_reg, c_rise_reg, d_rise_reg;
    logic [STAMP_BITS-1:0]   b_stamp_reg;
    logic [STAMP_BITS-1:0]   c_ticks_reg;
    logic [PROD_BITS-1:0]    d_prod_reg;
    logic                    d_fwd_hit_reg;
    logic [HELD_BITS-1:0]    d_fwd_data_reg;
    rcpwc_res_t              out_res_reg;

    // accept side
    logic [CH_AW-1:0]      s_ch_idx;
    logic                  s_in_range;
    logic                  s_rise;
    logic [STAMP_BITS-1:0] s_stamp;
    logic [STAMP_BITS-1:0] stamp_rd;
    logic [STAMP_BITS-1:0] b_ticks;

    // last stage
    logic [CH_AW-1:0]         c_ch_idx;
    logic [CH_AW-1:0]         d_ch_idx;
    logic [HELD_BITS-1:0]     acc_rd;
    logic [HELD_BITS-1:0]     d_held_rd;
    logic [STAMP_BITS-1:0]    d_quot;
    logic                     d_in_window;
    logic [WIDTH_US_BITS-1:0] d_width_sat;
    logic                     acc_we;
    logic [HELD_BITS-1:0]     acc_wdata;
    rcpwc_res_t               d_res;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_comb begin
        min_width_next = min_width_reg;
        max_width_next = max_width_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_MIN_WIDTH: min_width_next = cfg_data;
                REG_MAX_WIDTH: max_width_next = cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    assign out_free = !out_valid_reg || m_ready;
    assign d_go     = d_valid_reg && out_free;
    assign d_free   = !d_valid_reg || d_go;
    assign c_go     = c_valid_reg && d_free;
    assign c_free   = !c_valid_reg || c_go;
    assign b_go     = b_valid_reg && c_free;
    assign b_free   = !b_valid_reg || b_go;
    assign s_ready  = b_free;
    assign accept   = s_valid && b_free;

    assign b_valid_next   = accept || (b_valid_reg && !b_go);
    assign c_valid_next   = b_go || (c_valid_reg && !c_go);
    assign d_valid_next   = c_go || (d_valid_reg && !d_go);
    assign out_valid_next = d_go || (out_valid_reg && !m_ready);

    // ---------------- accept stage ----------------
    assign s_ch_idx   = CH_AW'(s_req.channel);
    assign s_in_range = 32'(s_req.channel) < CHANNELS;
    assign s_rise     = s_in_range && expect_rise_reg[s_ch_idx];
    assign s_stamp    = STAMP_BITS'(s_req.stamp);

    always_comb begin
        expect_rise_next = expect_rise_reg;
        if (accept && s_in_range) begin
            expect_rise_next[s_ch_idx] = !expect_rise_reg[s_ch_idx];
        end
    end

    rcpwc_ram #(
        .WIDTH(STAMP_BITS),
        .DEPTH(CHANNELS)
    ) u_stamp_ram (
        .aclk (aclk),
        .we   (accept && s_rise),
        .waddr(s_ch_idx),
        .wdata(s_stamp),
        .re   (accept),
        .raddr(s_ch_idx),
        .rdata(stamp_rd)
    );

    // down-counter: elapsed ticks wrap modulo 2^STAMP_BITS
    assign b_ticks = stamp_rd - b_stamp_reg;

    // ---------------- width stage ----------------
    assign c_ch_idx = CH_AW'(c_ch_reg);
    assign d_ch_idx = CH_AW'(d_ch_reg);

    rcpwc_ram #(
        .WIDTH(HELD_BITS),
        .DEPTH(CHANNELS)
    ) u_width_ram (
        .aclk (aclk),
        .we   (acc_we),
        .waddr(d_ch_idx),
        .wdata(acc_wdata),
        .re   (c_go),
        .raddr(c_ch_idx),
        .rdata(acc_rd)
    );

    assign d_quot      = STAMP_BITS'(d_prod_reg >> DIV_SHIFT);
    assign d_in_window = (d_quot >= STAMP_BITS'(min_width_reg)) &&
                         (d_quot <= STAMP_BITS'(max_width_reg));
    assign d_width_sat = (33'(d_quot) > 33'(WIDTH_US_MAX)) ? WIDTH_US_MAX
                                                           : WIDTH_US_BITS'(d_quot);
    assign d_held_rd   = d_fwd_hit_reg ? d_fwd_data_reg
                       : (acc_vld_reg[d_ch_idx] ? acc_rd : '0);

    assign acc_we    = d_go && d_in_range_reg && !d_rise_reg && d_in_window;
    assign acc_wdata = HELD_BITS'(d_quot);

    always_comb begin
        acc_vld_next = acc_vld_reg;
        if (acc_we) begin
            acc_vld_next[d_ch_idx] = 1'b1;
        end
    end

    always_comb begin
        d_res               = '0;
        d_res.out_channel   = d_ch_reg;
        d_res.event_kind    = EV_IGNORED;
        if (d_in_range_reg) begin
            if (d_rise_reg) begin
                d_res.event_kind    = EV_RISE;
                d_res.held_width_us = d_held_rd;
            end else if (d_in_window) begin
                d_res.event_kind    = EV_ACCEPT;
                d_res.width_us      = d_width_sat;
                d_res.held_width_us = acc_wdata;
            end else begin
                d_res.event_kind    = EV_REJECT;
                d_res.width_us      = d_width_sat;
                d_res.held_width_us = d_held_rd;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_res   = out_res_reg;

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_width_reg   <= MIN_WIDTH_RST;
            max_width_reg   <= MAX_WIDTH_RST;
            expect_rise_reg <= '1;
            acc_vld_reg     <= '0;
            b_valid_reg     <= 1'b0;
            c_valid_reg     <= 1'b0;
            d_valid_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            min_width_reg   <= min_width_next;
            max_width_reg   <= max_width_next;
            expect_rise_reg <= expect_rise_next;
            acc_vld_reg     <= acc_vld_next;
            b_valid_reg     <= b_valid_next;
            c_valid_reg     <= c_valid_next;
            d_valid_reg     <= d_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_ch_reg       <= s_req.channel;
            b_in_range_reg <= s_in_range;
            b_rise_reg     <= s_rise;
            b_stamp_reg    <= s_stamp;
        end
        if (b_go) begin
            c_ch_reg       <= b_ch_reg;
            c_in_range_reg <= b_in_range_reg;
            c_rise_reg     <= b_rise_reg;
            c_ticks_reg    <= b_ticks;
        end
        if (c_go) begin
            d_ch_reg       <= c_ch_reg;
            d_in_range_reg <= c_in_range_reg;
            d_rise_reg     <= c_rise_reg;
            d_prod_reg     <= PROD_BITS'(c_ticks_reg) * PROD_BITS'(RECIP);
            // write to the same channel on the read cycle is not in the RAM output
            d_fwd_hit_reg  <= acc_we && (d_ch_idx == c_ch_idx);
            d_fwd_data_reg <= acc_wdata;
        end
        if (d_go) begin
            out_res_reg    <= d_res;
        end
    end

endmodule

### rtl/rcpwc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the RC pulse width capture block, bound to the top level.
module rcpwc_checker #(
    parameter int CHANNELS = rcpwc_pkg::CHANNELS_DEF
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input rcpwc_pkg::rcpwc_res_t m_res
);
    import rcpwc_pkg::*;

    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res))
        else $error("result changed while stalled");

    a_in_range_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (32'(m_res.out_channel) < CHANNELS) |-> m_res.event_kind != EV_IGNORED)
        else $error("valid channel reported as ignored");

    a_ignored_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_res.event_kind == EV_IGNORED |->
            (32'(m_res.out_channel) >= CHANNELS) && m_res.width_us == '0 &&
            m_res.held_width_us == '0)
        else $error("ignored result malformed");

    a_rise_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_res.event_kind == EV_RISE |-> m_res.width_us == '0)
        else $error("rise result carries a width");

    a_accept_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_res.event_kind == EV_ACCEPT |->
            m_res.width_us == WIDTH_US_BITS'(m_res.held_width_us))
        else $error("accepted width not held");

endmodule

bind rc_pulse_width_capture rcpwc_checker #(
    .CHANNELS(CHANNELS)
) u_rcpwc_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_res  (m_res)
);

### tb/rcpwc_result_checker.sv
`timescale 1ns / 1ps
// Result checker for rc_pulse_width_capture: tracks requests, predicts results, compares.
module rcpwc_result_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  rcpwc_pkg::rcpwc_req_t                s_req,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  rcpwc_pkg::rcpwc_res_t                m_res,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [rcpwc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rcpwc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                   mismatches,
    output int                                   outstanding,
    output int                                   results_checked,
    output int                                   widths_kept
);
    import rcpwc_pkg::*;

    logic                      wait_rise [CHANNELS_DEF];
    logic [IN_STAMP_BITS-1:0]  rise_at   [CHANNELS_DEF];
    logic [HELD_BITS-1:0]      held_us   [CHANNELS_DEF];
    logic [HELD_BITS-1:0]      win_lo;
    logic [HELD_BITS-1:0]      win_hi;
    rcpwc_res_t                expected_results [$];
    int                        fail_count;
    int                        seen_count;
    int                        kept_count;

    // Per-channel edge decode; updates the channel state as the block should.
    function automatic rcpwc_res_t decode_edge(rcpwc_req_t ev);
        rcpwc_res_t                 r;
        logic [STAMP_BITS_DEF-1:0]  ticks;
        int unsigned                width;
        r.out_channel   = ev.channel;
        r.event_kind    = EV_IGNORED;
        r.width_us      = '0;
        r.held_width_us = '0;
        if (ev.channel < CHANNELS_DEF) begin
            if (wait_rise[ev.channel]) begin
                rise_at[ev.channel]   = ev.stamp;
                wait_rise[ev.channel] = 1'b0;
                r.event_kind          = EV_RISE;
            end else begin
                // down-counter: elapsed ticks wrap modulo the stamp width
                ticks = rise_at[ev.channel][STAMP_BITS_DEF-1:0] - ev.stamp[STAMP_BITS_DEF-1:0];
                width = ticks / TICKS_PER_US_DEF;
                if (width >= win_lo && width <= win_hi) begin
                    held_us[ev.channel] = HELD_BITS'(width);
                    r.event_kind        = EV_ACCEPT;
                end else begin
                    r.event_kind = EV_REJECT;
                end
                wait_rise[ev.channel] = 1'b1;
                r.width_us = (width > WIDTH_US_MAX) ? WIDTH_US_MAX : WIDTH_US_BITS'(width);
            end
            r.held_width_us = held_us[ev.channel];
        end
        return r;
    endfunction

    function automatic int field_wrong(string name, int unsigned want, int unsigned got,
                                       int unsigned ch);
        if (want == got)
            return 0;
        $display("%0t ns: ch %0d %s expected %0d got %0d", $time, ch, name, want, got);
        return 1;
    endfunction

    always @(posedge aclk) begin
        rcpwc_res_t want;
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS_DEF; i++) begin
                wait_rise[i] = 1'b1;
                rise_at[i]   = '0;
                held_us[i]   = '0;
            end
            win_lo = MIN_WIDTH_RST;
            win_hi = MAX_WIDTH_RST;
            expected_results.delete();
            fail_count = 0;
            seen_count = 0;
            kept_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MIN_WIDTH: win_lo = cfg_data;
                    REG_MAX_WIDTH: win_hi = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                seen_count++;
                if (expected_results.size() == 0) begin
                    $display({"%0t ns: result with nothing expected: ",
                              "ch %0d kind %0d width %0d held %0d"},
                             $time, m_res.out_channel, m_res.event_kind, m_res.width_us,
                             m_res.held_width_us);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.event_kind == EV_ACCEPT)
                        kept_count++;
                    fail_count += field_wrong("out_channel", want.out_channel,
                                              m_res.out_channel, want.out_channel);
                    fail_count += field_wrong("event_kind", int'(want.event_kind),
                                              int'(m_res.event_kind), want.out_channel);
                    fail_count += field_wrong("width_us", want.width_us,
                                              m_res.width_us, want.out_channel);
                    fail_count += field_wrong("held_width_us", want.held_width_us,
                                              m_res.held_width_us, want.out_channel);
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(decode_edge(s_req));
        end
        mismatches      <= fail_count;
        outstanding     <= expected_results.size();
        results_checked <= seen_count;
        widths_kept     <= kept_count;
    end

endmodule

### tb/rc_pulse_width_capture_test.sv
`timescale 1ns / 1ps
// Testbench top for rc_pulse_width_capture: clock, reset, edge stimulus and verdict.
module rc_pulse_width_capture_test;
    import rcpwc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASES        = 8;
    localparam int PHASE_EDGES   = 188;
    localparam int SETTLE_CYCLES = 12;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED = '1;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    rcpwc_req_t                s_req;
    logic                      m_valid;
    logic                      m_ready;
    rcpwc_res_t                m_res;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    int mismatches;
    int outstanding;
    int results_checked;
    int widths_kept;
    int gap_pct    = 0;
    int stall_pct  = 0;
    int cycles     = 0;
    int edges_sent = 0;

    logic [HELD_BITS-1:0]     cur_lo;
    logic [HELD_BITS-1:0]     cur_hi;
    bit                       rising_next [CHANNELS_DEF];
    logic [IN_STAMP_BITS-1:0] last_rise   [CHANNELS_DEF];

    rc_pulse_width_capture DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rcpwc_result_checker results_chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req           (s_req),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_res           (m_res),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .widths_kept     (widths_kept)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected", cycles, outstanding);
            $display("rc_pulse_width_capture_test: done, errors");
            $finish;
        end
    end

    initial m_ready = 1'b0;

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= stall_pct);

    // Keeps the per-channel rise/fall view used to shape stamps, then issues the request.
    task automatic send_tracked(input logic [CHANNEL_BITS-1:0] ch,
                                input logic [IN_STAMP_BITS-1:0] st);
        if (ch < CHANNELS_DEF) begin
            if (rising_next[ch])
                last_rise[ch] = st;
            rising_next[ch] = !rising_next[ch];
        end
        @(negedge aclk);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= '{channel: ch, stamp: st};
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        edges_sent++;
    endtask

    task automatic edge_pair(input logic [CHANNEL_BITS-1:0] ch,
                             input logic [IN_STAMP_BITS-1:0] rise,
                             input logic [IN_STAMP_BITS-1:0] ticks);
        send_tracked(ch, rise);
        send_tracked(ch, rise - ticks);
    endtask

    // Mostly well-formed rise/fall pairs with widths near the window edges,
    // plus out-of-range channels and falls at arbitrary stamps.
    task automatic random_edge();
        int                       pick;
        int                       us;
        logic [CHANNEL_BITS-1:0]  ch;
        logic [IN_STAMP_BITS-1:0] st;
        pick = $urandom_range(99);
        ch   = CHANNEL_BITS'($urandom_range(CHANNELS_DEF - 1));
        st   = IN_STAMP_BITS'($urandom);
        if (pick < 8) begin
            ch = CHANNEL_BITS'($urandom_range((1 << CHANNEL_BITS) - 1, CHANNELS_DEF));
        end else if (!rising_next[ch] && pick >= 15) begin
            case ($urandom_range(5))
                0: us = int'(cur_lo) - 1;
                1: us = cur_lo;
                2: us = cur_hi;
                3: us = int'(cur_hi) + 1;
                4: us = $urandom_range(4300);
                default: us = (cur_lo <= cur_hi) ? $urandom_range(cur_hi, cur_lo)
                                                 : $urandom_range(4095);
            endcase
            if (us < 0)
                us = 0;
            st = last_rise[ch] - IN_STAMP_BITS'(us * TICKS_PER_US_DEF
                                                + $urandom_range(TICKS_PER_US_DEF - 1));
        end
        send_tracked(ch, st);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
    endtask

    initial begin
        s_valid   = 1'b0;
        s_req     = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MIN_WIDTH;
        cfg_data  = '0;
        aresetn   = 1'b0;
        cur_lo    = MIN_WIDTH_RST;
        cur_hi    = MAX_WIDTH_RST;
        for (int i = 0; i < CHANNELS_DEF; i++) begin
            rising_next[i] = 1'b1;
            last_rise[i]   = '0;
        end
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // window edges at reset settings, truncation, wrap, full and zero spans
        edge_pair(3'd0, 24'h000000, 24'd96000);
        edge_pair(3'd1, 24'hFFFFFF, 24'd95999);
        edge_pair(3'd2, 24'd500000, 24'd264000);
        edge_pair(3'd3, 24'd500000, 24'd264120);
        edge_pair(3'd4, 24'd300000, 24'd264119);
        edge_pair(3'd5, 24'hFFFFFF, 24'hFFFFFF);
        edge_pair(3'd5, 24'd1234, 24'd0);
        edge_pair(3'd0, 24'h800000, 24'd180000);
        edge_pair(3'd0, 24'h000010, 24'd300000);
        edge_pair(3'd1, 24'h000001, 24'h800001);
        send_tracked(3'd6, 24'hFFFFFF);
        send_tracked(3'd7, 24'h000000);
        drain();
        write_reg(REG_UNMAPPED, '1);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0: begin cur_lo = MIN_WIDTH_RST; cur_hi = MAX_WIDTH_RST; end
                1: begin cur_lo = '0;            cur_hi = '1;            end
                2: begin cur_lo = '1;            cur_hi = '0;            end
                3: begin cur_lo = '0;            cur_hi = '0;            end
                4: begin cur_lo = '1;            cur_hi = '1;            end
                5: begin cur_lo = 12'd1000;      cur_hi = 12'd2000;      end
                6: begin cur_lo = 12'd1500;      cur_hi = 12'd1500;      end
                default: begin
                    cur_lo = HELD_BITS'($urandom_range(4095));
                    cur_hi = HELD_BITS'($urandom_range(4095));
                end
            endcase
            write_reg(REG_MIN_WIDTH, cur_lo);
            write_reg(REG_MAX_WIDTH, cur_hi);
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 54; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 54; end
                default: begin gap_pct = 30; stall_pct = 30; end
            endcase
            repeat (PHASE_EDGES) random_edge();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Sent %0d edges on all channel codes; %0d results checked, %0d widths kept.",
                 edges_sent, results_checked, widths_kept);
        $display("Windows: reset, full, empty, zero, top, narrow and random, under four pacing mixes.");
        if (mismatches == 0 && outstanding == 0)
            $display("rc_pulse_width_capture_test: done, clean");
        else
            $display("rc_pulse_width_capture_test: done, errors");
        $finish;
    end

endmodule

### filelist.f
rtl/rcpwc_pkg.sv
rtl/rcpwc_ram.sv
rtl/rc_pulse_width_capture.sv
rtl/rcpwc_checker.sv
tb/rcpwc_result_checker.sv
tb/rc_pulse_width_capture_test.sv
